// ===== rtl/spo_pkg.sv =====
// shared types and codes for the suffix-prefix overlap unit
package spo_pkg;

    typedef enum logic [1:0] {
        FUNC_LOAD_A = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_RUN    = 2'd2
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_CHECK = 2'd1,
        ST_CMP   = 2'd2,
        ST_DONE  = 2'd3
    } t_state;

    localparam int unsigned RES_W = 6;

endpackage

// ===== rtl/spo_ram.sv =====
// generic single-write, single-read ram with registered read data
module spo_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/suffix_prefix_overlap.sv =====
// suffix-prefix overlap unit: string stores, load counters and sweep sequencer
// a load transfer leaves busy low, so the next item is taken at once
// a compute transfer raises busy; each start position is checked and then compared byte by byte
// until a mismatch or the end of either string, and busy falls after the done state
// the result strobe comes in the first cycle with busy low; the receiver cannot stall
// synchronous active-low reset clears counts, overflow mark and sequencer; rams not cleared
module suffix_prefix_overlap
    import spo_pkg::*;
#(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_func,
    input  logic [7:0]           i_data_byte,
    output logic                 o_valid,
    output logic [RES_W-1:0]     o_overlap_len,
    output logic                 o_contained,
    output logic                 o_overflowed
);

    localparam int unsigned CW = $clog2(MAX_LEN + 1);
    localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_first_cnt, n_first_cnt;
    logic [CW-1:0]   r_second_cnt, n_second_cnt;
    logic            r_ovf, n_ovf;
    logic [CW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_j, n_j;
    logic [CW-1:0]   r_best, n_best;
    logic            r_in, n_in;
    logic            r_out_valid, n_out_valid;
    logic [RES_W-1:0] r_out_len, n_out_len;
    logic            r_out_in, n_out_in;
    logic            r_out_ovf, n_out_ovf;

    logic            w_accept;
    logic [CW-1:0]   w_pos;
    logic [CW:0]     w_fa;
    logic            w_more;
    logic            w_full;
    logic            w_reach;
    logic            w_match;
    logic            w_last;
    logic            w_we_a, w_we_b, w_re;
    logic [7:0]      w_rd_a, w_rd_b;
    logic [CW+RES_W-1:0] w_best_ext;

    assign w_accept = start && !busy;
    assign w_pos    = r_k - CW'(1);
    assign w_fa     = {1'b0, w_pos} + {1'b0, r_j};
    assign w_more   = (r_j < r_second_cnt) && (w_fa < {1'b0, r_first_cnt});
    assign w_full   = (r_j == r_second_cnt);
    assign w_reach  = (w_fa == {1'b0, r_first_cnt});
    assign w_match  = (w_rd_a == w_rd_b);
    assign w_last   = (r_k == CW'(1));
    assign w_best_ext = {{RES_W{1'b0}}, r_best};

    spo_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_first_cnt[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (w_re),
        .i_raddr (w_fa[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    spo_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_second_cnt[AW-1:0]),
        .i_wdata (i_data_byte),
        .i_re    (w_re),
        .i_raddr (r_j[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_func == FUNC_RUN) begin
                    n_state = (r_first_cnt == '0) ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_more) begin
                    n_state = ST_CMP;
                end else if (w_full || w_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_CMP: begin
                if (w_match) begin
                    n_state = ST_CHECK;
                end else if (w_last) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb begin
        busy         = (r_state != ST_IDLE);
        w_we_a       = 1'b0;
        w_we_b       = 1'b0;
        w_re         = 1'b0;
        n_first_cnt  = r_first_cnt;
        n_second_cnt = r_second_cnt;
        n_ovf        = r_ovf;
        n_k          = r_k;
        n_j          = r_j;
        n_best       = r_best;
        n_in         = r_in;
        n_out_valid  = 1'b0;
        n_out_len    = r_out_len;
        n_out_in     = r_out_in;
        n_out_ovf    = r_out_ovf;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        FUNC_LOAD_A: begin
                            if (r_first_cnt < CW'(MAX_LEN)) begin
                                w_we_a      = 1'b1;
                                n_first_cnt = r_first_cnt + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_LOAD_B: begin
                            if (r_second_cnt < CW'(MAX_LEN)) begin
                                w_we_b       = 1'b1;
                                n_second_cnt = r_second_cnt + CW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        FUNC_RUN: begin
                            n_k    = r_first_cnt;
                            n_j    = '0;
                            n_best = '0;
                            n_in   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (w_more) begin
                    w_re = 1'b1;
                end else begin
                    if (w_full) begin
                        n_best = r_second_cnt;
                        n_in   = 1'b1;
                    end else if (w_reach) begin
                        n_best = r_j;
                    end
                    n_k = r_k - CW'(1);
                    n_j = '0;
                end
            end
            ST_CMP: begin
                if (w_match) begin
                    n_j = r_j + CW'(1);
                end else begin
                    n_k = r_k - CW'(1);
                    n_j = '0;
                end
            end
            ST_DONE: begin
                n_out_valid  = 1'b1;
                n_out_len    = w_best_ext[RES_W-1:0];
                n_out_in     = r_in;
                n_out_ovf    = r_ovf;
                n_first_cnt  = '0;
                n_second_cnt = '0;
                n_ovf        = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_first_cnt  <= '0;
            r_second_cnt <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_first_cnt  <= n_first_cnt;
            r_second_cnt <= n_second_cnt;
            r_ovf        <= n_ovf;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_j       <= n_j;
        r_best    <= n_best;
        r_in      <= n_in;
        r_out_len <= n_out_len;
        r_out_in  <= n_out_in;
        r_out_ovf <= n_out_ovf;
    end

    assign o_valid       = r_out_valid;
    assign o_overlap_len = r_out_len;
    assign o_contained   = r_out_in;
    assign o_overflowed  = r_out_ovf;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func != FUNC_RUN) |=> !busy)
        else $error("load transfer left the unit busy");

    a_cmp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_j < r_second_cnt && w_fa < {1'b0, r_first_cnt}))
        else $error("compare beyond loaded bytes");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_k != '0 && r_k <= r_first_cnt))
        else $error("start position out of range");

    a_run_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_valid && !busy))
        else $error("finished sweep without result");
`endif

endmodule

// ===== bench/spo_overlap_checker.sv =====
// checker for the suffix-prefix overlap unit: tracks both strings and compares results
`timescale 1ns / 1ps
module spo_overlap_checker
    import spo_pkg::*;
#(
    parameter int unsigned MAX_LEN = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  logic [1:0]       i_func,
    input  logic [7:0]       i_data_byte,
    input  logic             i_valid,
    input  logic [RES_W-1:0] i_overlap_len,
    input  logic             i_contained,
    input  logic             i_overflowed,
    output int               o_waiting,
    output int               o_mismatches
);

    typedef struct packed {
        logic [RES_W-1:0] overlap_len;
        logic             contained;
        logic             overflowed;
    } t_answer;

    logic [7:0]  first_bytes [MAX_LEN];
    logic [7:0]  second_bytes [MAX_LEN];
    int unsigned first_len;
    int unsigned second_len;
    logic        lost_byte;
    t_answer     answer_q [$];
    int          mismatch_total;

    assign o_mismatches = mismatch_total;

    function automatic t_answer sweep_overlap();
        t_answer     ans;
        int unsigned best;
        int unsigned pos;
        int unsigned run;
        int unsigned k;
        logic        hit;
        best = 0;
        hit  = 1'b0;
        for (k = first_len; k > 0 && !hit; k--) begin
            pos = k - 1;
            run = 0;
            while (run < second_len && pos + run < first_len &&
                   first_bytes[pos + run] == second_bytes[run])
                run++;
            if (run == second_len) begin
                best = second_len;
                hit  = 1'b1;
            end else if (pos + run == first_len) begin
                best = run;
            end
        end
        ans.overlap_len = best[RES_W-1:0];
        ans.contained   = hit;
        ans.overflowed  = lost_byte;
        return ans;
    endfunction

    initial begin
        first_len      = 0;
        second_len     = 0;
        lost_byte      = 1'b0;
        mismatch_total = 0;
        o_waiting      = 0;
    end

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            first_len  = 0;
            second_len = 0;
            lost_byte  = 1'b0;
        end else begin
            if (i_valid) begin
                if (answer_q.size() == 0) begin
                    $error("result transfer with no result pending");
                    mismatch_total++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_overlap_len !== want.overlap_len) begin
                        $error("overlap_len expected %0d got %0d",
                               want.overlap_len, i_overlap_len);
                        mismatch_total++;
                    end
                    if (i_contained !== want.contained) begin
                        $error("contained expected %0d got %0d",
                               want.contained, i_contained);
                        mismatch_total++;
                    end
                    if (i_overflowed !== want.overflowed) begin
                        $error("overflowed expected %0d got %0d",
                               want.overflowed, i_overflowed);
                        mismatch_total++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                case (i_func)
                    FUNC_LOAD_A: begin
                        if (first_len < MAX_LEN) begin
                            first_bytes[first_len] = i_data_byte;
                            first_len++;
                        end else begin
                            lost_byte = 1'b1;
                        end
                    end
                    FUNC_LOAD_B: begin
                        if (second_len < MAX_LEN) begin
                            second_bytes[second_len] = i_data_byte;
                            second_len++;
                        end else begin
                            lost_byte = 1'b1;
                        end
                    end
                    FUNC_RUN: begin
                        answer_q.push_back(sweep_overlap());
                        first_len  = 0;
                        second_len = 0;
                        lost_byte  = 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_waiting <= answer_q.size();
    end

endmodule

// ===== bench/suffix_prefix_overlap_tb.sv =====
// stimulus and verdict for the suffix-prefix overlap unit
`timescale 1ns / 1ps
module suffix_prefix_overlap_tb
    import spo_pkg::*;
();

    localparam int unsigned MAX_LEN     = 32;
    localparam logic [1:0]  FUNC_UNUSED = 2'd3;
    localparam int          ITEM_TARGET = 700;
    localparam int          TAIL_CYCLES = MAX_LEN * (2 * MAX_LEN + 1) + 20;
    localparam int          CYCLE_LIMIT = 5_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [1:0]       i_func = FUNC_LOAD_A;
    logic [7:0]       i_data_byte = 8'h00;
    logic             busy;
    logic             o_valid;
    logic [RES_W-1:0] o_overlap_len;
    logic             o_contained;
    logic             o_overflowed;

    int waiting;
    int mismatches;
    int cycles = 0;
    int items_sent = 0;
    bit calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    suffix_prefix_overlap #(
        .MAX_LEN(MAX_LEN)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_func(i_func),
        .i_data_byte(i_data_byte),
        .o_valid(o_valid),
        .o_overlap_len(o_overlap_len),
        .o_contained(o_contained),
        .o_overflowed(o_overflowed)
    );

    spo_overlap_checker #(
        .MAX_LEN(MAX_LEN)
    ) i_checker (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_func(i_func),
        .i_data_byte(i_data_byte),
        .i_valid(o_valid),
        .i_overlap_len(o_overlap_len),
        .i_contained(o_contained),
        .i_overflowed(o_overflowed),
        .o_waiting(waiting),
        .o_mismatches(mismatches)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("suffix_prefix_overlap_tb failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return $urandom_range(MAX_LEN, MAX_LEN + 4);
        else if (r < 3)
            return $urandom_range(9, MAX_LEN - 1);
        else
            return $urandom_range(0, 8);
    endfunction

    function automatic logic [7:0] pick_char(input logic [7:0] base, input bit wide);
        logic [7:0] val;
        if (wide)
            val = 8'($urandom_range(0, 255));
        else
            val = base ^ {6'd0, 2'($urandom_range(0, 2))};
        return val;
    endfunction

    // one transfer, after a random idle stretch that may be empty
    task automatic issue(input logic [1:0] func, input logic [7:0] byte_val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= func;
        i_data_byte <= byte_val;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (func != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic run_string_pair();
        logic [7:0] first_q [$];
        logic [7:0] second_q [$];
        logic [7:0] base;
        bit         wide;
        int         first_n;
        int         second_n;
        int         kept;
        int         shape;
        int         k;
        int         pos;
        int         i;
        base     = 8'($urandom_range(0, 255));
        wide     = ($urandom_range(0, 4) == 0);
        first_n  = pick_len();
        second_n = pick_len();
        for (i = 0; i < first_n; i++)
            first_q.push_back(pick_char(base, wide));
        kept  = (first_n > MAX_LEN) ? MAX_LEN : first_n;
        shape = $urandom_range(0, 3);
        if (shape == 3 && kept > 0) begin
            pos = $urandom_range(0, kept - 1);
            k   = $urandom_range(0, kept - pos);
            for (i = 0; i < k; i++)
                second_q.push_back(first_q[pos + i]);
        end else if (shape != 0) begin
            k = $urandom_range(0, (kept < second_n) ? kept : second_n);
            for (i = 0; i < k; i++)
                second_q.push_back(first_q[kept - k + i]);
        end
        while (second_q.size() < second_n)
            second_q.push_back(pick_char(base, wide));
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 6))
                issue(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
        while (first_q.size() + second_q.size() > 0) begin
            if (second_q.size() == 0 || (first_q.size() > 0 && $urandom_range(0, 1) == 0))
                issue(FUNC_LOAD_A, first_q.pop_front());
            else
                issue(FUNC_LOAD_B, second_q.pop_front());
            if ($urandom_range(0, 29) == 0)
                issue(FUNC_UNUSED, 8'($urandom_range(0, 255)));
        end
        issue(FUNC_RUN, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both strings empty
        issue(FUNC_RUN, 8'h00);
        // empty second string inside a nonempty first
        issue(FUNC_LOAD_A, 8'h00);
        issue(FUNC_LOAD_A, 8'hFF);
        issue(FUNC_RUN, 8'hFF);
        // plain overlap, unused code in between
        issue(FUNC_LOAD_A, 8'h10);
        issue(FUNC_UNUSED, 8'hA5);
        issue(FUNC_LOAD_A, 8'h20);
        issue(FUNC_LOAD_B, 8'h20);
        issue(FUNC_LOAD_A, 8'h30);
        issue(FUNC_LOAD_B, 8'h30);
        issue(FUNC_LOAD_B, 8'h40);
        issue(FUNC_RUN, 8'h5A);
        // second string wholly inside the first
        issue(FUNC_LOAD_A, 8'h01);
        issue(FUNC_LOAD_A, 8'h02);
        issue(FUNC_LOAD_A, 8'h03);
        issue(FUNC_LOAD_A, 8'h04);
        issue(FUNC_LOAD_B, 8'h02);
        issue(FUNC_LOAD_B, 8'h03);
        issue(FUNC_RUN, 8'h00);
        // empty first string
        issue(FUNC_LOAD_B, 8'h55);
        issue(FUNC_RUN, 8'h00);

        items_sent = 0;
        while (items_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 4) == 0);
            run_string_pair();
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (waiting != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("suffix_prefix_overlap_tb passed");
        else
            $display("suffix_prefix_overlap_tb failed");
        $finish;
    end

endmodule
